[src/drc_pkg.sv]
// Shared types, constants and tables for the grid ray caster.
`timescale 1ns / 1ps

package drc_pkg;

    localparam int IN_W  = 32;
    localparam int OUT_W = 88;

    localparam int DIV_NW = 31;
    localparam int DIV_DW = 33;

    localparam logic [3:0]  CORDIC_LAST = 4'd14;
    localparam logic [9:0]  WALK_LIMIT  = 10'd512;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [14:0] PLANE_Q14   = 15'sd10813;
    localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFF;

    localparam logic [2:0] REG_POS_X    = 3'd0;
    localparam logic [2:0] REG_POS_Y    = 3'd1;
    localparam logic [2:0] REG_ANGLE    = 3'd2;
    localparam logic [2:0] REG_SCR_W    = 3'd3;
    localparam logic [2:0] REG_SCR_H    = 3'd4;
    localparam logic [2:0] REG_GRID_W   = 3'd5;
    localparam logic [2:0] REG_GRID_H   = 3'd6;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_COR_INIT,
        CMD_COR_STEP,
        CMD_HEAD,
        CMD_PLANE_MUL,
        CMD_PLANE_RND,
        CMD_DIV_CAM,
        CMD_CAM,
        CMD_RAY_MUL,
        CMD_RAY,
        CMD_DIV_DX,
        CMD_DDX,
        CMD_DIV_DY,
        CMD_DDY,
        CMD_SIDE,
        CMD_STEP,
        CMD_CHECK,
        CMD_TEX_MUL,
        CMD_DIV_HH,
        CMD_FINISH
    } cmd_op_t;

    typedef struct packed {
        logic    load;
        cmd_op_t op;
        logic    out_load;
    } drc_cmd_t;

    typedef struct packed {
        logic is_cast;
        logic cor_last;
        logic div_busy;
        logic hit;
        logic out_busy;
    } drc_status_t;

    // arctangent of 2^-i in 1/4096 degree
    function automatic logic signed [21:0] cordic_atan(input logic [3:0] i);
        logic signed [21:0] r;
        case (i)
            4'd0:    r = 22'sd184320;
            4'd1:    r = 22'sd108810;
            4'd2:    r = 22'sd57492;
            4'd3:    r = 22'sd29184;
            4'd4:    r = 22'sd14649;
            4'd5:    r = 22'sd7331;
            4'd6:    r = 22'sd3667;
            4'd7:    r = 22'sd1833;
            4'd8:    r = 22'sd917;
            4'd9:    r = 22'sd458;
            4'd10:   r = 22'sd229;
            4'd11:   r = 22'sd115;
            4'd12:   r = 22'sd57;
            4'd13:   r = 22'sd29;
            4'd14:   r = 22'sd14;
            default: r = 22'sd0;
        endcase
        return r;
    endfunction

endpackage

[src/drc_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module drc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [drc_pkg::DIV_NW-1:0] num,
    input  logic [drc_pkg::DIV_DW-1:0] den,
    output logic                       busy,
    output logic [drc_pkg::DIV_NW-1:0] quo
);
    import drc_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic [DIV_NW-1:0] q_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   rem_sh;
    logic              take;
    logic [DIV_DW:0]   rem_sub;

    assign rem_sh  = {rem_reg, q_reg[DIV_NW-1]};
    assign take    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DIV_NW);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            q_reg   <= {q_reg[DIV_NW-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

[src/drc_dp.sv]
// Datapath: registers, tile map, CORDIC, DDA walk and result formatting.
`timescale 1ns / 1ps

module drc_dp #(
    parameter int MAP_CELLS          = 4096,
    parameter int TEXTURE_SIZE       = 64,
    parameter int OUT_OF_BOUNDS_TILE = 255
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  drc_pkg::drc_cmd_t         cmd,
    output drc_pkg::drc_status_t      st,
    input  logic [drc_pkg::IN_W-1:0]  in_data,
    input  logic                      in_op,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [drc_pkg::OUT_W-1:0] out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [13:0]               cfg_data
);
    import drc_pkg::*;

    localparam int AW = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
    localparam logic [7:0] OOB = OUT_OF_BOUNDS_TILE[7:0];

    // configuration
    logic [13:0] pos_x_reg, pos_y_reg;
    logic [12:0] angle_reg;
    logic [11:0] scr_w_reg, scr_h_reg;
    logic [6:0]  grid_w_reg, grid_h_reg;

    // item
    logic        op_reg;
    logic [11:0] cell_index_reg;
    logic [7:0]  cell_value_reg;
    logic [10:0] column_reg;

    // heading and ray
    logic signed [33:0] x_reg, y_reg;
    logic signed [21:0] z_reg;
    logic [3:0]         iter_reg;
    logic               neg_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic signed [30:0] pmx_reg, pmy_reg;
    logic signed [15:0] plx_reg, ply_reg, cam_reg;
    logic signed [31:0] rmx_reg, rmy_reg;
    logic signed [16:0] rx_reg, ry_reg;
    logic [31:0]        ddx_reg, ddy_reg;

    // walk
    logic [31:0]        sdx_reg, sdy_reg, dist_reg;
    logic signed [8:0]  mx_reg, my_reg;
    logic [9:0]         steps_reg;
    logic               side_reg;
    logic               oob_reg;
    logic [7:0]         rdata_reg;
    logic [7:0]         tile_reg;
    logic signed [49:0] tprod_reg;

    // results
    logic [7:0]  res_wall_reg;
    logic        res_side_reg;
    logic [7:0]  res_mx_reg, res_my_reg;
    logic [15:0] res_cd_reg, res_hh_reg;
    logic [10:0] res_top_reg, res_bot_reg;
    logic [5:0]  res_tex_reg;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [7:0] mem [MAP_CELLS];

    // divider
    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_busy;
    logic [DIV_NW-1:0] div_quo;

    drc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // clamped sizes and column
    logic [11:0] w_eff, h_eff, w_m1, h_m1;
    logic [10:0] col_eff;

    always_comb
    begin
        if (scr_w_reg == 12'd0)
            w_eff = 12'd1;
        else if (scr_w_reg > 12'd2048)
            w_eff = 12'd2048;
        else
            w_eff = scr_w_reg;
        if (scr_h_reg < 12'd2)
            h_eff = 12'd2;
        else if (scr_h_reg > 12'd2048)
            h_eff = 12'd2048;
        else
            h_eff = scr_h_reg;
        w_m1 = w_eff - 12'd1;
        h_m1 = h_eff - 12'd1;
        col_eff = ({1'b0, column_reg} > w_m1) ? w_m1[10:0] : column_reg;
    end

    // angle reduction
    logic [12:0]        a_mod;
    logic signed [13:0] a_red;
    logic               a_neg;

    always_comb
    begin
        a_mod = (angle_reg >= 13'd5760) ? angle_reg - 13'd5760 : angle_reg;
        a_neg = 1'b0;
        if (a_mod > 13'd1440 && a_mod < 13'd4320)
        begin
            a_red = $signed({1'b0, a_mod}) - 14'sd2880;
            a_neg = 1'b1;
        end
        else if (a_mod >= 13'd4320)
            a_red = $signed({1'b0, a_mod}) - 14'sd5760;
        else
            a_red = $signed({1'b0, a_mod});
    end

    // cordic step and heading rounding
    logic signed [33:0] xs, ys, xr, yr;
    logic signed [15:0] xc, yc;

    always_comb
    begin
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        xr = (x_reg + 34'sd32768) >>> 16;
        yr = (y_reg + 34'sd32768) >>> 16;
        if (xr > 34'sd16384)
            xc = 16'sd16384;
        else if (xr < -34'sd16384)
            xc = -16'sd16384;
        else
            xc = xr[15:0];
        if (yr > 34'sd16384)
            yc = 16'sd16384;
        else if (yr < -34'sd16384)
            yc = -16'sd16384;
        else
            yc = yr[15:0];
    end

    // plane and ray rounding
    logic signed [30:0] pmx_rnd, pmy_rnd;
    logic signed [31:0] rmx_rnd, rmy_rnd;
    logic signed [16:0] rx_next, ry_next;
    logic [16:0]        rx_abs, ry_abs;

    always_comb
    begin
        pmx_rnd = (pmx_reg + 31'sd8192) >>> 14;
        pmy_rnd = (pmy_reg + 31'sd8192) >>> 14;
        rmx_rnd = (rmx_reg + 32'sd8192) >>> 14;
        rmy_rnd = (rmy_reg + 32'sd8192) >>> 14;
        rx_next = $signed({dx_reg[15], dx_reg}) + $signed(rmx_rnd[16:0]);
        ry_next = $signed({dy_reg[15], dy_reg}) + $signed(rmy_rnd[16:0]);
        rx_abs  = rx_reg[16] ? 17'(-rx_reg) : 17'(rx_reg);
        ry_abs  = ry_reg[16] ? 17'(-ry_reg) : 17'(ry_reg);
    end

    // divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            CMD_DIV_CAM:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({col_eff, 15'd0});
                div_den   = DIV_DW'(w_eff);
            end
            CMD_DIV_DX:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'(1) << 30;
                div_den   = DIV_DW'(rx_abs);
            end
            CMD_DIV_DY:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'(1) << 30;
                div_den   = DIV_DW'(ry_abs);
            end
            CMD_DIV_HH:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({h_eff, 15'd0});
                div_den   = DIV_DW'(dist_reg) + DIV_DW'(7);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // initial side distances
    logic [8:0]  fpx, fpy;
    logic [40:0] spx, spy;
    logic [31:0] sdx_init, sdy_init;

    always_comb
    begin
        fpx = rx_reg[16] ? {1'b0, pos_x_reg[7:0]} : 9'd256 - {1'b0, pos_x_reg[7:0]};
        fpy = ry_reg[16] ? {1'b0, pos_y_reg[7:0]} : 9'd256 - {1'b0, pos_y_reg[7:0]};
        spx = 41'(fpx) * 41'(ddx_reg);
        spy = 41'(fpy) * 41'(ddy_reg);
        sdx_init = (spx[40] != 1'b0) ? DIST_SAT : spx[39:8];
        sdy_init = (spy[40] != 1'b0) ? DIST_SAT : spy[39:8];
    end

    // one DDA step
    logic               step_x;
    logic [32:0]        sdx_sum, sdy_sum;
    logic [31:0]        sdx_adv, sdy_adv;
    logic signed [8:0]  mx_next, my_next;
    logic [13:0]        row_off;
    logic [16:0]        cell_idx;
    logic               oob_next;
    logic [16:0]        widx;
    logic               wr_ok;
    logic [7:0]         tile_now;

    always_comb
    begin
        step_x  = sdx_reg < sdy_reg;
        sdx_sum = {1'b0, sdx_reg} + {1'b0, ddx_reg};
        sdy_sum = {1'b0, sdy_reg} + {1'b0, ddy_reg};
        sdx_adv = sdx_sum[32] ? DIST_SAT : sdx_sum[31:0];
        sdy_adv = sdy_sum[32] ? DIST_SAT : sdy_sum[31:0];
        mx_next = mx_reg;
        my_next = my_reg;
        if (step_x)
            mx_next = rx_reg[16] ? mx_reg - 9'sd1 : mx_reg + 9'sd1;
        else
            my_next = ry_reg[16] ? my_reg - 9'sd1 : my_reg + 9'sd1;
        row_off  = my_next[6:0] * grid_w_reg;
        cell_idx = 17'(row_off) + 17'(mx_next[6:0]);
        oob_next = mx_next[8] || my_next[8]
                || (mx_next[7:0] >= {1'b0, grid_w_reg})
                || (my_next[7:0] >= {1'b0, grid_h_reg})
                || (32'(cell_idx) >= 32'(MAP_CELLS));
        widx     = 17'(cell_index_reg);
        wr_ok    = 32'(cell_index_reg) < 32'(MAP_CELLS);
        tile_now = oob_reg ? OOB : rdata_reg;
    end

    // finishing arithmetic
    logic [15:0] hh_sat;
    logic [10:0] half_h;
    logic [16:0] bot_sum;
    logic [15:0] frac;
    logic [24:0] tex_full;
    logic [13:0] base_pos;

    always_comb
    begin
        hh_sat   = (div_quo[DIV_NW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
        half_h   = h_eff[11:1];
        bot_sum  = 17'(half_h) + 17'(hh_sat);
        base_pos = side_reg ? pos_x_reg : pos_y_reg;
        frac     = {base_pos[7:0], 8'd0} + tprod_reg[29:14];
        tex_full = 25'(frac) * 25'(TEXTURE_SIZE);
    end

    // configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            angle_reg     <= '0;
            scr_w_reg     <= 12'd320;
            scr_h_reg     <= 12'd200;
            grid_w_reg    <= 7'd8;
            grid_h_reg    <= 7'd8;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_POS_X:  pos_x_reg  <= cfg_data;
                    REG_POS_Y:  pos_y_reg  <= cfg_data;
                    REG_ANGLE:  angle_reg  <= cfg_data[12:0];
                    REG_SCR_W:  scr_w_reg  <= cfg_data[11:0];
                    REG_SCR_H:  scr_h_reg  <= cfg_data[11:0];
                    REG_GRID_W: grid_w_reg <= cfg_data[6:0];
                    REG_GRID_H: grid_h_reg <= cfg_data[6:0];
                    default:    angle_reg  <= angle_reg;
                endcase
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // tile map
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_WRITE && wr_ok)
            mem[widx[AW-1:0]] <= cell_value_reg;
        if (cmd.op == CMD_STEP)
            rdata_reg <= mem[cell_idx[AW-1:0]];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= in_op;
            cell_index_reg <= in_data[11:0];
            cell_value_reg <= in_data[19:12];
            column_reg     <= in_data[30:20];
        end
        if (cmd.out_load)
            out_data_reg <= {3'd0, res_tex_reg, res_bot_reg, res_top_reg, res_hh_reg,
                             res_cd_reg, res_my_reg, res_mx_reg, res_side_reg, res_wall_reg};
        unique case (cmd.op)
            CMD_WRITE:
            begin
                res_wall_reg <= '0;
                res_side_reg <= 1'b0;
                res_mx_reg   <= '0;
                res_my_reg   <= '0;
                res_cd_reg   <= '0;
                res_hh_reg   <= '0;
                res_top_reg  <= '0;
                res_bot_reg  <= '0;
                res_tex_reg  <= '0;
            end
            CMD_COR_INIT:
            begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= {a_red, 8'd0};
                neg_reg  <= a_neg;
                iter_reg <= '0;
            end
            CMD_COR_STEP:
            begin
                if (!z_reg[21])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - cordic_atan(iter_reg);
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + cordic_atan(iter_reg);
                end
                iter_reg <= iter_reg + 4'd1;
            end
            CMD_HEAD:
            begin
                dx_reg <= neg_reg ? -xc : xc;
                dy_reg <= neg_reg ? -yc : yc;
            end
            CMD_PLANE_MUL:
            begin
                pmx_reg <= dy_reg * PLANE_Q14;
                pmy_reg <= dx_reg * PLANE_Q14;
            end
            CMD_PLANE_RND:
            begin
                plx_reg <= -$signed(pmx_rnd[15:0]);
                ply_reg <= $signed(pmy_rnd[15:0]);
            end
            CMD_CAM:
                cam_reg <= $signed({1'b0, div_quo[14:0]}) - 16'sd16384;
            CMD_RAY_MUL:
            begin
                rmx_reg <= plx_reg * cam_reg;
                rmy_reg <= ply_reg * cam_reg;
            end
            CMD_RAY:
            begin
                rx_reg <= rx_next;
                ry_reg <= ry_next;
            end
            CMD_DDX:
                ddx_reg <= (rx_reg == '0) ? DIST_SAT : 32'(div_quo);
            CMD_DDY:
                ddy_reg <= (ry_reg == '0) ? DIST_SAT : 32'(div_quo);
            CMD_SIDE:
            begin
                sdx_reg   <= sdx_init;
                sdy_reg   <= sdy_init;
                mx_reg    <= $signed({3'd0, pos_x_reg[13:8]});
                my_reg    <= $signed({3'd0, pos_y_reg[13:8]});
                steps_reg <= '0;
                dist_reg  <= '0;
                side_reg  <= 1'b0;
            end
            CMD_STEP:
            begin
                if (steps_reg == WALK_LIMIT)
                    oob_reg <= 1'b1;
                else
                begin
                    steps_reg <= steps_reg + 10'd1;
                    mx_reg    <= mx_next;
                    my_reg    <= my_next;
                    oob_reg   <= oob_next;
                    side_reg  <= !step_x;
                    if (step_x)
                    begin
                        dist_reg <= sdx_reg;
                        sdx_reg  <= sdx_adv;
                    end
                    else
                    begin
                        dist_reg <= sdy_reg;
                        sdy_reg  <= sdy_adv;
                    end
                end
            end
            CMD_CHECK:
                tile_reg <= tile_now;
            CMD_TEX_MUL:
                tprod_reg <= (side_reg ? rx_reg : ry_reg) * $signed({1'b0, dist_reg});
            CMD_FINISH:
            begin
                res_wall_reg <= tile_reg;
                res_side_reg <= side_reg;
                res_mx_reg   <= mx_reg[7:0];
                res_my_reg   <= my_reg[7:0];
                res_cd_reg   <= (dist_reg[31:24] != 8'd0) ? 16'hFFFF : dist_reg[23:8];
                res_hh_reg   <= hh_sat;
                res_top_reg  <= ({5'd0, half_h} > hh_sat) ? half_h - hh_sat[10:0] : 11'd0;
                res_bot_reg  <= (bot_sum > 17'(h_m1)) ? h_m1[10:0] : bot_sum[10:0];
                res_tex_reg  <= tex_full[21:16];
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

    assign st.is_cast  = op_reg;
    assign st.cor_last = iter_reg == CORDIC_LAST;
    assign st.div_busy = div_busy;
    assign st.hit      = tile_now != 8'd0;
    assign st.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

[src/drc_ctrl.sv]
// Sequencer that steps the datapath through one write or cast transaction.
`timescale 1ns / 1ps

module drc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  drc_pkg::drc_status_t st,
    output drc_pkg::drc_cmd_t    cmd
);
    import drc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_COR_INIT,
        S_COR_STEP,
        S_HEAD,
        S_PLANE_MUL,
        S_PLANE_RND,
        S_CAM_DIV,
        S_CAM_WAIT,
        S_RAY_MUL,
        S_RAY,
        S_DX_DIV,
        S_DX_WAIT,
        S_DY_DIV,
        S_DY_WAIT,
        S_SIDE,
        S_STEP,
        S_CHECK,
        S_TEX_MUL,
        S_HH_DIV,
        S_HH_WAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.op       = CMD_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:    state_next = st.is_cast ? S_COR_INIT : S_WRITE;
            S_WRITE:
            begin
                cmd.op     = CMD_WRITE;
                state_next = S_OUT;
            end
            S_COR_INIT:
            begin
                cmd.op     = CMD_COR_INIT;
                state_next = S_COR_STEP;
            end
            S_COR_STEP:
            begin
                cmd.op = CMD_COR_STEP;
                if (st.cor_last)
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.op     = CMD_HEAD;
                state_next = S_PLANE_MUL;
            end
            S_PLANE_MUL:
            begin
                cmd.op     = CMD_PLANE_MUL;
                state_next = S_PLANE_RND;
            end
            S_PLANE_RND:
            begin
                cmd.op     = CMD_PLANE_RND;
                state_next = S_CAM_DIV;
            end
            S_CAM_DIV:
            begin
                cmd.op     = CMD_DIV_CAM;
                state_next = S_CAM_WAIT;
            end
            S_CAM_WAIT:
            begin
                if (!st.div_busy)
                begin
                    cmd.op     = CMD_CAM;
                    state_next = S_RAY_MUL;
                end
            end
            S_RAY_MUL:
            begin
                cmd.op     = CMD_RAY_MUL;
                state_next = S_RAY;
            end
            S_RAY:
            begin
                cmd.op     = CMD_RAY;
                state_next = S_DX_DIV;
            end
            S_DX_DIV:
            begin
                cmd.op     = CMD_DIV_DX;
                state_next = S_DX_WAIT;
            end
            S_DX_WAIT:
            begin
                if (!st.div_busy)
                begin
                    cmd.op     = CMD_DDX;
                    state_next = S_DY_DIV;
                end
            end
            S_DY_DIV:
            begin
                cmd.op     = CMD_DIV_DY;
                state_next = S_DY_WAIT;
            end
            S_DY_WAIT:
            begin
                if (!st.div_busy)
                begin
                    cmd.op     = CMD_DDY;
                    state_next = S_SIDE;
                end
            end
            S_SIDE:
            begin
                cmd.op     = CMD_SIDE;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.op     = CMD_STEP;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op     = CMD_CHECK;
                state_next = st.hit ? S_TEX_MUL : S_STEP;
            end
            S_TEX_MUL:
            begin
                cmd.op     = CMD_TEX_MUL;
                state_next = S_HH_DIV;
            end
            S_HH_DIV:
            begin
                cmd.op     = CMD_DIV_HH;
                state_next = S_HH_WAIT;
            end
            S_HH_WAIT:
            begin
                if (!st.div_busy)
                begin
                    cmd.op     = CMD_FINISH;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

[src/dda_raycast_column.sv]
// Top level of the grid ray caster for one screen column.
//
//  channel  direction  handshake                    contents
//  s_axis   in         s_axis_tvalid/s_axis_tready  map write or column cast
//  m_axis   out        m_axis_tvalid/m_axis_tready  hit description
//  cfg      in         cfg_valid/cfg_ready          register index and value
//
// A map write passes the idle, decode, write and output states. A cast runs
// four divides on the shared one-bit-per-cycle divider (each an issue and a
// wait state), 15 CORDIC iterations, and a walk loop with a step and a check
// state for each map cell crossed, the check waiting on the map RAM read. Reset
// loads the default configuration; the map is not cleared. A stalled result sits
// in the output register while the next transaction is accepted; that transaction completes once the register is free.
`timescale 1ns / 1ps

module dda_raycast_column #(
    parameter int MAP_CELLS          = 4096,
    parameter int TEXTURE_SIZE       = 64,
    parameter int OUT_OF_BOUNDS_TILE = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // cell_index, cell_value, column
    input  logic [0:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // wall_type, hit_side, hit_cell_x, hit_cell_y,
                                       // corrected_distance, half_height, wall_top,
                                       // wall_bottom, texture_column
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);
    import drc_pkg::*;

    drc_cmd_t    cmd;
    drc_status_t st;

    drc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    drc_dp #(
        .MAP_CELLS          (MAP_CELLS),
        .TEXTURE_SIZE       (TEXTURE_SIZE),
        .OUT_OF_BOUNDS_TILE (OUT_OF_BOUNDS_TILE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser[0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
